>>> hw/rtl/glyph_atlas_shelf_packer_defines.svh
// Assertion macros shared by the glyph atlas shelf packer RTL.
// No dependencies; each macro compiles to nothing when SYNTHESIS is defined.
`ifndef GLYPH_ATLAS_SHELF_PACKER_DEFINES_SVH
`define GLYPH_ATLAS_SHELF_PACKER_DEFINES_SVH
`ifndef SYNTHESIS
// Checks a property on every clock edge outside reset.
`define GASP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a condition in one cycle leads to a property in the next.
`define GASP_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`else
`define GASP_ASSERT(lbl, prop, msg)
`define GASP_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

>>> hw/rtl/gasp_pkg.sv
// Package of the glyph atlas shelf packer: types and fixed constants.
// No dependencies.
package gasp_pkg;

  // Seen bitmap rows are 2**ROW_BITS bits wide.
  localparam int ROW_BITS = 5;
  localparam int ROW_W    = 1 << ROW_BITS;

  localparam int PAGE_SIZE_W = 13;
  localparam int COORD_W     = 16;
  localparam int DIM_W       = 12;
  localparam int PCOUNT_W    = 17;

  localparam logic [PAGE_SIZE_W-1:0] PAGE_SIZE_RESET = 13'd1024;
  localparam logic [PCOUNT_W-1:0]    PAGE_LIMIT      = 17'h10000;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

>>> hw/rtl/gasp_seen_mem.sv
// Seen bitmap memory of the glyph atlas shelf packer, with its clearing pass.
// Depends on gasp_pkg.
module gasp_seen_mem #(
  parameter int ADDR_W = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gasp_pkg::mem_ctl_t         ctl,
  input  logic [ADDR_W-1:0]          rd_addr,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [gasp_pkg::ROW_W-1:0] wr_data,
  output logic [gasp_pkg::ROW_W-1:0] rd_data,
  output logic                       busy
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [gasp_pkg::ROW_W-1:0] mem [DEPTH];
  logic [gasp_pkg::ROW_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]          clr_addr_r;
  logic [ADDR_W-1:0]          clr_addr_nxt;
  logic                       clearing_r;
  logic                       clearing_nxt;

  // One row is zeroed per cycle after reset.
  always_comb begin
    clr_addr_nxt = clr_addr_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == {ADDR_W{1'b1}}) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clearing_r <= 1'b1;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      clearing_r <= clearing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= '0;
    end else if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clearing_r;

endmodule

>>> hw/rtl/glyph_atlas_shelf_packer.sv
// Top level of the glyph atlas shelf packer: control, packing datapath, result register.
// Depends on gasp_pkg, gasp_seen_mem and glyph_atlas_shelf_packer_defines.svh.
//
// Usage:
// Each input transfer carries one character code with its render result and the
// fit and glyph sizes. Every input transfer produces exactly one output transfer
// that says whether the code was already present, whether a rectangle was placed,
// whether a page was opened, and the page index and rectangle corners.
// The page size register is written through cfg_wr_en / cfg_wr_data while the
// block is idle; it takes effect for the next input transfer.
// The accepting cycle reads the row of the seen bitmap that holds the code, and the
// next cycle computes the placement, writes the row back and loads the output
// register. Because of the single-port style read-then-write of that bitmap row,
// the block takes no new item until the one under work has loaded the output
// register; the result is offered from that register.
// When the receiver stalls, the finished result waits in the output register and
// the block holds the item under work until that register frees.
// After reset the seen bitmap is cleared one 32-bit row per cycle, over all
// 2**(CODE_BITS-5) rows (2048 for the default); in_tready stays low during that
// pass, while configuration writes are taken as ever. The cursor, row height and
// page count reset to zero, and the page size to 1024.
`include "glyph_atlas_shelf_packer_defines.svh"

module glyph_atlas_shelf_packer #(
  parameter int CODE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] code_point, [27:16] fit_width, [39:28] fit_height,
  // [51:40] glyph_width, [63:52] glyph_height
  input  logic [63:0] in_tdata,
  // [0] render_ok
  input  logic [0:0]  in_tuser,
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] page_index, [31:16] rect_left, [47:32] rect_top,
  // [63:48] rect_right, [79:64] rect_bottom
  output logic [79:0] out_tdata,
  // [0] already_present, [1] placed, [2] page_opened
  output logic [2:0]  out_tuser,
  // Configuration: page_size.
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data
);

  localparam int ADDR_W = CODE_BITS - gasp_pkg::ROW_BITS;
  localparam int CW     = gasp_pkg::COORD_W;
  localparam int PW     = gasp_pkg::PCOUNT_W;

  gasp_pkg::state_t state_r, state_nxt;

  // Item under work, captured at the input transfer.
  logic [15:0]                 code_r;
  logic                        ok_r;
  logic [gasp_pkg::DIM_W-1:0]  fw_r, fh_r, gw_r, gh_r;

  // Packer state.
  logic [CW-1:0]                   cursor_x_r, cursor_x_nxt;
  logic [CW-1:0]                   cursor_y_r, cursor_y_nxt;
  logic [CW-1:0]                   row_height_r, row_height_nxt;
  logic [PW-1:0]                   page_count_r, page_count_nxt;
  logic [gasp_pkg::PAGE_SIZE_W-1:0] page_size_r;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [79:0] out_tdata_r, out_tdata_nxt;
  logic [2:0]  out_tuser_r, out_tuser_nxt;

  // Memory interface.
  gasp_pkg::mem_ctl_t         mem_ctl;
  logic [gasp_pkg::ROW_W-1:0] row_data;
  logic [gasp_pkg::ROW_W-1:0] row_wdata;
  logic                       clr_busy;

  logic                       in_fire;
  logic                       calc_go;
  logic [CODE_BITS-1:0]       idx_in, idx_r;
  logic [gasp_pkg::ROW_BITS-1:0] bit_sel;
  logic                       present;

  // Datapath terms.
  logic [PW-1:0] pc_base, pc_new;
  logic          open_first, open_new, can_open;
  logic          wrap, over;
  logic [CW-1:0] x1, y1, y2, rh1, rh2, h1, cx2;
  logic [CW-1:0] page_idx;

  gasp_seen_mem #(
    .ADDR_W(ADDR_W)
  ) u_seen (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mem_ctl),
    .rd_addr(idx_in[CODE_BITS-1:gasp_pkg::ROW_BITS]),
    .wr_addr(idx_r[CODE_BITS-1:gasp_pkg::ROW_BITS]),
    .wr_data(row_wdata),
    .rd_data(row_data),
    .busy   (clr_busy)
  );

  // Codes that agree in the low CODE_BITS bits share one seen bit.
  assign idx_in  = CODE_BITS'(in_tdata[15:0]);
  assign idx_r   = CODE_BITS'(code_r);
  assign bit_sel = idx_r[gasp_pkg::ROW_BITS-1:0];
  assign present = row_data[bit_sel];
  assign row_wdata = row_data | (gasp_pkg::ROW_W'(1) << bit_sel);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gasp_pkg::S_CLEAR: begin
        if (!clr_busy) begin
          state_nxt = gasp_pkg::S_IDLE;
        end
      end
      gasp_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = gasp_pkg::S_CALC;
        end
      end
      gasp_pkg::S_CALC: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = gasp_pkg::S_IDLE;
        end
      end
      default: state_nxt = gasp_pkg::S_CLEAR;
    endcase
  end

  // FSM outputs. The row write of one item always lands before the next read,
  // so no forwarding is needed.
  always_comb begin
    in_tready     = 1'b0;
    calc_go       = 1'b0;
    case (state_r)
      gasp_pkg::S_IDLE: in_tready = 1'b1;
      gasp_pkg::S_CALC: calc_go   = !out_valid_r || out_tready;
      default: begin
        in_tready = 1'b0;
        calc_go   = 1'b0;
      end
    endcase
  end

  assign in_fire       = in_tvalid && in_tready;
  assign mem_ctl.rd_en = in_fire;
  assign mem_ctl.wr_en = calc_go && !present && ok_r;

  // Placement. The overflow compares run at 17 bits without wrap; the cursor
  // arithmetic wraps at 16 bits.
  always_comb begin
    open_first = (page_count_r == '0);
    pc_base    = open_first ? PW'(1) : page_count_r;
    wrap       = ({1'b0, cursor_x_r} + PW'(fw_r) + PW'(1)) > PW'(page_size_r);
    x1         = wrap ? '0 : cursor_x_r;
    y1         = wrap ? (cursor_y_r + row_height_r + CW'(1)) : cursor_y_r;
    rh1        = wrap ? '0 : row_height_r;
    over       = ({1'b0, y1} + PW'(fh_r)) > PW'(page_size_r);
    can_open   = pc_base < gasp_pkg::PAGE_LIMIT;
    open_new   = over && can_open;
    pc_new     = open_new ? (pc_base + PW'(1)) : pc_base;
    y2         = over ? '0 : y1;
    h1         = CW'(gh_r) + CW'(1);
    rh2        = (h1 > rh1) ? h1 : rh1;
    cx2        = x1 + CW'(gw_r) + CW'(1);
    page_idx   = CW'(pc_new - PW'(1));
  end

  // State update and result assembly.
  always_comb begin
    cursor_x_nxt   = cursor_x_r;
    cursor_y_nxt   = cursor_y_r;
    row_height_nxt = row_height_r;
    page_count_nxt = page_count_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    if (calc_go) begin
      out_valid_nxt = 1'b1;
      if (present) begin
        out_tdata_nxt = '0;
        out_tuser_nxt = 3'b001;
      end else if (!ok_r) begin
        // A failed render only opens the first page if none exists.
        page_count_nxt = pc_base;
        out_tdata_nxt  = '0;
        out_tuser_nxt  = {open_first, 1'b0, 1'b0};
      end else begin
        page_count_nxt = pc_new;
        cursor_x_nxt   = cx2;
        cursor_y_nxt   = y2;
        row_height_nxt = rh2;
        out_tdata_nxt  = {y2 + CW'(gh_r), x1 + CW'(gw_r), y2, x1, page_idx};
        out_tuser_nxt  = {open_first || open_new, 1'b1, 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gasp_pkg::S_CLEAR;
      cursor_x_r   <= '0;
      cursor_y_r   <= '0;
      row_height_r <= '0;
      page_count_r <= '0;
      page_size_r  <= gasp_pkg::PAGE_SIZE_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cursor_x_r   <= cursor_x_nxt;
      cursor_y_r   <= cursor_y_nxt;
      row_height_r <= row_height_nxt;
      page_count_r <= page_count_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        page_size_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    if (in_fire) begin
      code_r <= in_tdata[15:0];
      fw_r   <= in_tdata[27:16];
      fh_r   <= in_tdata[39:28];
      gw_r   <= in_tdata[51:40];
      gh_r   <= in_tdata[63:52];
      ok_r   <= in_tuser[0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `GASP_ASSERT_NEXT(a_accept_to_calc, in_fire, state_r == gasp_pkg::S_CALC,
    "input transfer did not move the packer into its compute cycle")
  `GASP_ASSERT(a_no_rw_overlap, !(mem_ctl.rd_en && mem_ctl.wr_en),
    "seen bitmap read and write issued in the same cycle")
  `GASP_ASSERT(a_page_limit, page_count_r <= gasp_pkg::PAGE_LIMIT,
    "page count exceeded its limit")
  `GASP_ASSERT_NEXT(a_state_hold, !calc_go,
    $stable(cursor_x_r) && $stable(cursor_y_r) && $stable(page_count_r),
    "packer state changed outside a compute cycle")
  `GASP_ASSERT(a_no_accept_clear, (state_r == gasp_pkg::S_CLEAR) |-> !in_tready,
    "input accepted during the bitmap clearing pass")

endmodule

>>> tb/sv/tb_glyph_atlas_shelf_packer.sv
// Self-checking testbench of the glyph atlas shelf packer: directed and random glyph streams
// across several page sizes, checked against an in-bench shelf packing predictor.
// Depends on gasp_pkg and the glyph_atlas_shelf_packer RTL.
module tb_glyph_atlas_shelf_packer;

  // One glyph request as it travels on the input channel.
  typedef struct packed {
    logic [15:0]                code;
    logic                       render_ok;
    logic [gasp_pkg::DIM_W-1:0] fit_w;
    logic [gasp_pkg::DIM_W-1:0] fit_h;
    logic [gasp_pkg::DIM_W-1:0] glyph_w;
    logic [gasp_pkg::DIM_W-1:0] glyph_h;
  } glyph_req_t;

  // One placement report as it comes back on the result channel.
  typedef struct packed {
    logic                         already_present;
    logic                         placed;
    logic                         page_opened;
    logic [gasp_pkg::COORD_W-1:0] page_index;
    logic [gasp_pkg::COORD_W-1:0] rect_left;
    logic [gasp_pkg::COORD_W-1:0] rect_top;
    logic [gasp_pkg::COORD_W-1:0] rect_right;
    logic [gasp_pkg::COORD_W-1:0] rect_bottom;
  } placement_t;

  localparam int CLK_HALF = 6;
  localparam int RANDOM_PER_PHASE = 155;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [12:0] cfg_wr_data = '0;

  glyph_atlas_shelf_packer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // Glyph requests waiting for the driver, and placements predicted for requests that the
  // block has already taken, oldest first.
  glyph_req_t glyph_q[$];
  placement_t placement_q[$];
  logic [15:0] used_codes[$];
  int err_count = 0;
  int result_count = 0;
  // Requests handed to the driver so far, and requests the block has taken so far.
  int queued_total = 0;
  int sent_count = 0;

  // Predicted packer state: the seen bitmap, the shelf cursor, the current row height,
  // the number of pages opened so far, and the page size register.
  bit                               code_seen [0:65535];
  logic [gasp_pkg::COORD_W-1:0]     shelf_x = '0;
  logic [gasp_pkg::COORD_W-1:0]     shelf_y = '0;
  logic [gasp_pkg::COORD_W-1:0]     shelf_h = '0;
  logic [gasp_pkg::PCOUNT_W-1:0]    pages_open = '0;
  logic [gasp_pkg::PAGE_SIZE_W-1:0] page_dim = gasp_pkg::PAGE_SIZE_RESET;

  // Works out the placement of one glyph and advances the predicted packer state.
  // The overflow tests are done on 32-bit sums, so they never wrap; the cursor and
  // row height updates are 16-bit and do.
  function automatic placement_t place_glyph(input glyph_req_t g);
    placement_t p;
    logic [gasp_pkg::COORD_W-1:0] tall;
    p = '0;
    if (code_seen[g.code]) begin
      p.already_present = 1'b1;
      return p;
    end
    // The very first new code opens page 0, whether or not its render worked.
    if (pages_open == '0) begin
      pages_open = 17'd1;
      p.page_opened = 1'b1;
    end
    if (g.render_ok) begin
      if (32'(shelf_x) + 32'(g.fit_w) + 32'd1 > 32'(page_dim)) begin
        shelf_y = shelf_y + shelf_h + 16'd1;
        shelf_x = '0;
        shelf_h = '0;
      end
      // A page change only rewinds y; x and the row height carry over.
      if (32'(shelf_y) + 32'(g.fit_h) > 32'(page_dim)) begin
        if (pages_open < gasp_pkg::PAGE_LIMIT) begin
          pages_open = pages_open + 17'd1;
          p.page_opened = 1'b1;
        end
        shelf_y = '0;
      end
      p.placed      = 1'b1;
      p.page_index  = 16'(pages_open - 17'd1);
      p.rect_left   = shelf_x;
      p.rect_top    = shelf_y;
      p.rect_right  = shelf_x + 16'(g.glyph_w);
      p.rect_bottom = shelf_y + 16'(g.glyph_h);
      shelf_x = shelf_x + 16'(g.glyph_w) + 16'd1;
      tall = 16'(g.glyph_h) + 16'd1;
      if (tall > shelf_h) shelf_h = tall;
      code_seen[g.code] = 1'b1;
    end
    return p;
  endfunction

  function automatic glyph_req_t make_glyph(input logic [15:0] code, input logic ok,
                                            input int fw, input int fh,
                                            input int gw, input int gh);
    glyph_req_t g;
    g.code      = code;
    g.render_ok = ok;
    g.fit_w     = gasp_pkg::DIM_W'(fw);
    g.fit_h     = gasp_pkg::DIM_W'(fh);
    g.glyph_w   = gasp_pkg::DIM_W'(gw);
    g.glyph_h   = gasp_pkg::DIM_W'(gh);
    return g;
  endfunction

  // Random glyph: sizes mostly scaled to the page so that rows and pages fill up over a few
  // dozen glyphs, a quarter of the codes repeated, and a few failed renders.
  function automatic glyph_req_t random_glyph(input int unsigned page_sz);
    glyph_req_t g;
    int unsigned span;
    span = page_sz / 3;
    if (span < 4) span = 4;
    if (span > 4095) span = 4095;
    if (used_codes.size() > 0 && $urandom_range(0, 3) == 0)
      g.code = used_codes[$urandom_range(0, used_codes.size() - 1)];
    else
      g.code = 16'($urandom_range(0, 65535));
    used_codes.insert(used_codes.size(), g.code);
    g.render_ok = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 7) == 0) begin
      g.fit_w   = gasp_pkg::DIM_W'($urandom);
      g.fit_h   = gasp_pkg::DIM_W'($urandom);
      g.glyph_w = gasp_pkg::DIM_W'($urandom);
      g.glyph_h = gasp_pkg::DIM_W'($urandom);
    end else begin
      g.glyph_w = gasp_pkg::DIM_W'($urandom_range(0, span));
      g.glyph_h = gasp_pkg::DIM_W'($urandom_range(0, span));
      g.fit_w   = g.glyph_w;
      g.fit_h   = g.glyph_h;
      // Now and then the bitmap size used for fitting differs from the placed size.
      if ($urandom_range(0, 7) == 0) g.fit_w = gasp_pkg::DIM_W'($urandom_range(0, span));
      if ($urandom_range(0, 7) == 0) g.fit_h = gasp_pkg::DIM_W'($urandom_range(0, span));
    end
    return g;
  endfunction

  // Hands one request to the driver.
  task automatic queue_glyph(input glyph_req_t g);
    glyph_q.insert(glyph_q.size(), g);
    queued_total++;
  endtask

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
             result_count, what, got, want);
    err_count++;
  endtask

  // Driver. A request on the bus is taken at the edge where in_tvalid and in_tready are
  // both high; its placement is predicted right there, so the predictor always sees the
  // page size that the block used. The sender works in bursts, with gaps after some of them.
  glyph_req_t on_bus;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        placement_q.insert(placement_q.size(), place_glyph(on_bus));
        sent_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (glyph_q.size() > 0) begin
          on_bus = glyph_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {on_bus.glyph_h, on_bus.glyph_w, on_bus.fit_h, on_bus.fit_w,
                        on_bus.code};
          in_tuser  <= on_bus.render_ok;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            // Half of the bursts run straight into the next one.
            gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each result transfer is compared field by field with the oldest predicted
  // placement. The receiver switches between a few stall patterns: always ready, mostly
  // ready, mostly stalled, and a fixed two-in-eight duty cycle.
  int stall_mode = 0;
  int mode_left = 0;
  int cycle_count = 0;

  always @(posedge clk) begin
    placement_t got;
    placement_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.already_present = out_tuser[0];
        got.placed          = out_tuser[1];
        got.page_opened     = out_tuser[2];
        got.page_index      = out_tdata[15:0];
        got.rect_left       = out_tdata[31:16];
        got.rect_top        = out_tdata[47:32];
        got.rect_right      = out_tdata[63:48];
        got.rect_bottom     = out_tdata[79:64];
        if (placement_q.size() == 0) begin
          report_mismatch("result with nothing pending, page_index", got.page_index, '0);
        end else begin
          want = placement_q.pop_front();
          if (got.already_present !== want.already_present)
            report_mismatch("already_present", 16'(got.already_present),
                            16'(want.already_present));
          if (got.placed !== want.placed)
            report_mismatch("placed", 16'(got.placed), 16'(want.placed));
          if (got.page_opened !== want.page_opened)
            report_mismatch("page_opened", 16'(got.page_opened), 16'(want.page_opened));
          if (got.page_index !== want.page_index)
            report_mismatch("page_index", got.page_index, want.page_index);
          if (got.rect_left !== want.rect_left)
            report_mismatch("rect_left", got.rect_left, want.rect_left);
          if (got.rect_top !== want.rect_top)
            report_mismatch("rect_top", got.rect_top, want.rect_top);
          if (got.rect_right !== want.rect_right)
            report_mismatch("rect_right", got.rect_right, want.rect_right);
          if (got.rect_bottom !== want.rect_bottom)
            report_mismatch("rect_bottom", got.rect_bottom, want.rect_bottom);
        end
        result_count++;
      end
      cycle_count++;
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= ($urandom_range(0, 2) == 0);
        default: out_tready <= ((cycle_count % 8) < 2);
      endcase
    end
  end

  // Waits until every queued request has been taken and every result has come back,
  // then lets a few cycles pass so that the block is idle for sure.
  task automatic wait_drained();
    while (sent_count != queued_total || result_count != sent_count) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Page size writes happen only while the block is idle.
  task automatic write_page_size(input logic [gasp_pkg::PAGE_SIZE_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    page_dim = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Page sizes of the random phases: the smallest and largest legal sizes, zero and one,
  // the widest value the register holds, sizes that are no power of two, and the reset value.
  logic [gasp_pkg::PAGE_SIZE_W-1:0] phase_sizes [10] =
    '{13'd2, 13'd4096, 13'd64, 13'd0, 13'd1, 13'd8191, 13'd300, 13'd1000, 13'd128, 13'd1024};

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, at the reset page size of 1024. The first new code fails to render
    // and still opens page 0; its retry is placed; a third try is already present.
    queue_glyph(make_glyph(16'h0041, 1'b0, 10, 12, 10, 12));
    queue_glyph(make_glyph(16'h0041, 1'b1, 10, 12, 10, 12));
    queue_glyph(make_glyph(16'h0041, 1'b1, 10, 12, 10, 12));
    // Smallest and largest codes and sizes.
    queue_glyph(make_glyph(16'h0000, 1'b1, 0, 0, 0, 0));
    queue_glyph(make_glyph(16'hFFFF, 1'b1, 4095, 4095, 4095, 4095));
    queue_glyph(make_glyph(16'hFFFF, 1'b0, 0, 0, 0, 0));
    // A failed render of a new code once pages exist: nothing is placed or opened.
    queue_glyph(make_glyph(16'h1234, 1'b0, 4095, 4095, 4095, 4095));
    // Fit sizes that differ from the placed sizes in both directions.
    queue_glyph(make_glyph(16'h1234, 1'b1, 0, 0, 4095, 4095));
    queue_glyph(make_glyph(16'h1235, 1'b1, 4095, 0, 0, 0));
    queue_glyph(make_glyph(16'h1236, 1'b1, 1, 4095, 17, 3));
    // Fits that land exactly on the page edge, then one pixel over it.
    queue_glyph(make_glyph(16'h2000, 1'b1, 1023, 1024, 1023, 1024));
    queue_glyph(make_glyph(16'h2001, 1'b1, 1022, 1023, 1022, 1023));
    queue_glyph(make_glyph(16'h2002, 1'b1, 1023, 1025, 5, 5));
    // Alternating bit patterns in every field.
    queue_glyph(make_glyph(16'hAAAA, 1'b1, 12'hAAA, 12'h555, 12'hAAA, 12'h555));
    queue_glyph(make_glyph(16'h5555, 1'b1, 12'h555, 12'hAAA, 12'h555, 12'hAAA));
    queue_glyph(make_glyph(16'h5555, 1'b0, 12'hAAA, 12'h555, 12'hAAA, 12'h555));
    wait_drained();

    // Random phases, one per page size. Half way through each phase the sender holds
    // off until every placement has come back.
    foreach (phase_sizes[p]) begin
      write_page_size(phase_sizes[p]);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        queue_glyph(random_glyph(phase_sizes[p]));
        if (i == RANDOM_PER_PHASE / 2) wait_drained();
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Guards against a hung handshake: far beyond the slowest correct run, including the
  // seen bitmap clearing pass after reset.
  initial begin
    #(2 * CLK_HALF * 400000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/gasp_pkg.sv
hw/rtl/gasp_seen_mem.sv
hw/rtl/glyph_atlas_shelf_packer.sv
tb/sv/tb_glyph_atlas_shelf_packer.sv
